// ===== src/mlfq_pkg.sv =====
// Package for the three-level feedback queue scheduler with thread admission.
// Holds the sequencer states, status, level and register codes, and reset defaults.
// No dependencies.
package mlfq_pkg;

  localparam int unsigned MAX_PROCS_DEF = 16;
  localparam int unsigned ID_BITS_DEF   = 16;
  localparam int unsigned TIME_BITS_DEF = 32;

  localparam logic [7:0] TOP_SLICE_RST = 8'd5;
  localparam logic [7:0] MID_SLICE_RST = 8'd10;

  localparam logic [1:0] REG_TOTAL = 2'd0;
  localparam logic [1:0] REG_TOP   = 2'd1;
  localparam logic [1:0] REG_MID   = 2'd2;

  localparam logic OP_ADMIT    = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  localparam logic [2:0] ST_READY    = 3'd0;
  localparam logic [2:0] ST_WAITING  = 3'd1;
  localparam logic [2:0] ST_TOO_MANY = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_DISPATCH = 3'd4;
  localparam logic [2:0] ST_IDLE_RES = 3'd5;

  localparam logic [1:0] RING_TOP  = 2'd0;
  localparam logic [1:0] RING_MID  = 2'd1;
  localparam logic [1:0] RING_BOT  = 2'd2;
  localparam logic [1:0] RING_WAIT = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PROMOTE,
    S_PICK,
    S_ACCUM,
    S_EMIT
  } seq_state_e;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] run_id;
    logic [1:0]  run_level;
    logic [7:0]  slice_length;
    logic [15:0] iterations_left;
    logic        finished;
    logic [4:0]  moved;
  } result_t;

endpackage

// ===== src/mlfq_scheduler_thread_admission_top.sv =====
// Top level of the three-level feedback queue scheduler with thread admission.
// Sequence: a rejected admit goes straight to emit; other admits scan for a free slot,
// one slot a cycle; dispatch promotes wait-queue heads, one per cycle, then picks, then
// accumulates time unless idle, then emits; a stalled output holds the emit state.
// Throughput: one item at a time; the input is not ready until the result is registered.
// Reset clears all rings, frees all slots, zeroes the pool and time, and loads slice defaults.
// Depends on mlfq_pkg.
module mlfq_scheduler_thread_admission_top #(
  parameter int unsigned MAX_PROCS = mlfq_pkg::MAX_PROCS_DEF,
  parameter int unsigned ID_BITS   = mlfq_pkg::ID_BITS_DEF,
  parameter int unsigned TIME_BITS = mlfq_pkg::TIME_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // proc_id[15:0], threads_needed[23:16], own_slice[31:24], iterations[47:32]
  input  logic [47:0] s_axis_tdata_i,
  // op[0]
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // run_id[15:0], run_level[17:16], slice_length[25:18], iterations_left[41:26],
  // finished[42], threads_free[50:43], elapsed_total[82:51], moved_from_wait[87:83]
  output logic [87:0] m_axis_tdata_o,
  // status[2:0]
  output logic [2:0]  m_axis_tuser_o
);
  import mlfq_pkg::*;

  localparam int unsigned IDXW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned CNTW = IDXW + 1;

  seq_state_e state_q, state_d;

  logic [7:0]           total_q, top_q, mid_q, pool_q;
  logic [TIME_BITS-1:0] time_q;
  logic [MAX_PROCS-1:0] in_use_q;

  logic [ID_BITS-1:0]   id_q;
  logic [7:0]           thr_q, own_q;
  logic [15:0]          iters_q;
  logic [IDXW-1:0]      scan_q;
  logic [CNTW-1:0]      moved_q;
  logic [7:0]           slice_q;
  result_t              res_q;

  logic [ID_BITS-1:0]   slot_id_q   [MAX_PROCS];
  logic [7:0]           slot_thr_q  [MAX_PROCS];
  logic [7:0]           slot_own_q  [MAX_PROCS];
  logic [15:0]          slot_iter_q [MAX_PROCS];

  logic [IDXW-1:0]      ring_q [4][MAX_PROCS];
  logic [IDXW-1:0]      head_q [4];
  logic [CNTW-1:0]      cnt_q  [4];

  logic                 push_en [4];
  logic                 pop_en  [4];
  logic [IDXW-1:0]      push_val[4];
  logic [IDXW-1:0]      front   [4];

  logic                 out_valid_q;
  logic [87:0]          out_data_q;
  logic [2:0]           out_user_q;

  logic                 in_xfer, out_free;
  logic [IDXW-1:0]      wfront;
  logic                 wait_go;
  logic                 any_run;
  logic [1:0]           pick_lvl;
  logic [IDXW-1:0]      pick_slot;
  logic [15:0]          pick_left;
  logic                 pick_fin;
  logic [7:0]           pick_slice;
  logic [8:0]           pool_sum;
  logic [TIME_BITS:0]   time_sum;
  logic [63:0]          time_ext;

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE);

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      front[r] = ring_q[r][head_q[r]];
    end
  end

  assign wfront  = front[RING_WAIT];
  assign wait_go = (cnt_q[RING_WAIT] != '0) && (slot_thr_q[wfront] <= pool_q);
  assign any_run = (cnt_q[RING_TOP] != '0) || (cnt_q[RING_MID] != '0) ||
                   (cnt_q[RING_BOT] != '0);

  always_comb begin
    if (cnt_q[RING_TOP] != '0) begin
      pick_lvl = RING_TOP;
    end else if (cnt_q[RING_MID] != '0) begin
      pick_lvl = RING_MID;
    end else begin
      pick_lvl = RING_BOT;
    end
  end

  assign pick_slot = front[pick_lvl];
  assign pick_left = (slot_iter_q[pick_slot] == 16'd0) ? 16'd0 :
                     slot_iter_q[pick_slot] - 16'd1;
  assign pick_fin  = (pick_left == 16'd0);

  always_comb begin
    case (pick_lvl)
      RING_TOP: pick_slice = top_q;
      RING_MID: pick_slice = mid_q;
      default:  pick_slice = slot_own_q[pick_slot];
    endcase
  end

  assign pool_sum = {1'b0, pool_q} + {1'b0, slot_thr_q[pick_slot]};
  assign time_sum = {1'b0, time_q} + (TIME_BITS + 1)'(slice_q);
  assign time_ext = 64'(time_q);

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      push_en[r]  = 1'b0;
      pop_en[r]   = 1'b0;
      push_val[r] = '0;
    end
    case (state_q)
      S_SCAN: begin
        if (!in_use_q[scan_q]) begin
          if (thr_q <= pool_q) begin
            push_en[RING_TOP]  = 1'b1;
            push_val[RING_TOP] = scan_q;
          end else begin
            push_en[RING_WAIT]  = 1'b1;
            push_val[RING_WAIT] = scan_q;
          end
        end
      end
      S_PROMOTE: begin
        if (wait_go) begin
          pop_en[RING_WAIT]  = 1'b1;
          push_en[RING_TOP]  = 1'b1;
          push_val[RING_TOP] = wfront;
        end
      end
      S_PICK: begin
        if (any_run) begin
          pop_en[pick_lvl] = 1'b1;
          if (!pick_fin) begin
            if (pick_lvl == RING_TOP) begin
              push_en[RING_MID]  = 1'b1;
              push_val[RING_MID] = pick_slot;
            end else begin
              push_en[RING_BOT]  = 1'b1;
              push_val[RING_BOT] = pick_slot;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (s_axis_tuser_i == OP_ADMIT) begin
            state_d = (s_axis_tdata_i[23:16] > total_q) ? S_EMIT : S_SCAN;
          end else begin
            state_d = S_PROMOTE;
          end
        end
      end
      S_SCAN: begin
        if (!in_use_q[scan_q] || (32'(scan_q) == MAX_PROCS - 1)) begin
          state_d = S_EMIT;
        end
      end
      S_PROMOTE: begin
        if (!wait_go) begin
          state_d = S_PICK;
        end
      end
      S_PICK:  state_d = any_run ? S_ACCUM : S_EMIT;
      S_ACCUM: state_d = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 4; r++) begin
        head_q[r] <= '0;
        cnt_q[r]  <= '0;
      end
    end else begin
      for (int r = 0; r < 4; r++) begin
        if (pop_en[r]) begin
          head_q[r] <= (32'(head_q[r]) == MAX_PROCS - 1) ? '0 : head_q[r] + 1'b1;
        end
        if (push_en[r] && !pop_en[r]) begin
          cnt_q[r] <= cnt_q[r] + 1'b1;
        end else if (pop_en[r] && !push_en[r]) begin
          cnt_q[r] <= cnt_q[r] - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 4; r++) begin
      logic [CNTW-1:0] widx;
      widx = CNTW'(head_q[r]) + cnt_q[r];
      if (32'(widx) >= MAX_PROCS) begin
        widx = widx - CNTW'(MAX_PROCS);
      end
      if (push_en[r]) begin
        ring_q[r][widx[IDXW-1:0]] <= push_val[r];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_SCAN && !in_use_q[scan_q]) begin
      slot_id_q[scan_q]   <= id_q;
      slot_thr_q[scan_q]  <= thr_q;
      slot_own_q[scan_q]  <= own_q;
      slot_iter_q[scan_q] <= iters_q;
    end else if (state_q == S_PICK && any_run) begin
      slot_iter_q[pick_slot] <= pick_left;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= 8'd0;
      top_q    <= TOP_SLICE_RST;
      mid_q    <= MID_SLICE_RST;
      pool_q   <= 8'd0;
      time_q   <= '0;
      in_use_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TOTAL: begin
            total_q <= cfg_data_i;
            pool_q  <= cfg_data_i;
          end
          REG_TOP: top_q <= cfg_data_i;
          REG_MID: mid_q <= cfg_data_i;
          default: ;
        endcase
      end else begin
        case (state_q)
          S_SCAN: begin
            if (!in_use_q[scan_q]) begin
              in_use_q[scan_q] <= 1'b1;
              if (thr_q <= pool_q) begin
                pool_q <= pool_q - thr_q;
              end
            end
          end
          S_PROMOTE: begin
            if (wait_go) begin
              pool_q <= pool_q - slot_thr_q[wfront];
            end
          end
          S_PICK: begin
            if (any_run && pick_fin) begin
              pool_q <= pool_sum[8] ? 8'hFF : pool_sum[7:0];
              in_use_q[pick_slot] <= 1'b0;
            end
          end
          S_ACCUM: begin
            time_q <= time_sum[TIME_BITS] ? '1 : time_sum[TIME_BITS-1:0];
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        id_q    <= ID_BITS'(s_axis_tdata_i[15:0]);
        thr_q   <= s_axis_tdata_i[23:16];
        own_q   <= s_axis_tdata_i[31:24];
        iters_q <= s_axis_tdata_i[47:32];
        scan_q  <= '0;
        moved_q <= '0;
        res_q   <= '{status: ST_TOO_MANY, run_id: 16'(ID_BITS'(s_axis_tdata_i[15:0])),
                     run_level: 2'd0, slice_length: 8'd0,
                     iterations_left: s_axis_tdata_i[47:32], finished: 1'b0, moved: 5'd0};
      end
      S_SCAN: begin
        if (!in_use_q[scan_q]) begin
          res_q.status <= (thr_q <= pool_q) ? ST_READY : ST_WAITING;
        end else begin
          res_q.status <= ST_FULL;
          scan_q <= scan_q + 1'b1;
        end
      end
      S_PROMOTE: begin
        if (wait_go) begin
          moved_q <= moved_q + 1'b1;
        end
      end
      S_PICK: begin
        slice_q <= pick_slice;
        if (any_run) begin
          res_q <= '{status: ST_DISPATCH, run_id: 16'(slot_id_q[pick_slot]),
                     run_level: pick_lvl, slice_length: pick_slice,
                     iterations_left: pick_left, finished: pick_fin,
                     moved: 5'(moved_q)};
        end else begin
          res_q <= '{status: ST_IDLE_RES, run_id: 16'd0, run_level: 2'd0,
                     slice_length: 8'd0, iterations_left: 16'd0, finished: 1'b0,
                     moved: 5'(moved_q)};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_EMIT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_EMIT && out_free) begin
      out_user_q <= res_q.status;
      out_data_q <= {res_q.moved, time_ext[31:0], pool_q, res_q.finished,
                     res_q.iterations_left, res_q.slice_length, res_q.run_level,
                     res_q.run_id};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

// ===== src/mlfq_checker.sv =====
// Port-level checker for the feedback queue scheduler top level, with its bind.
// Depends on mlfq_pkg and mlfq_scheduler_thread_admission_top.
module mlfq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [87:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o
);
  import mlfq_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input ready right after a transfer");

  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == ST_IDLE_RES) |->
      (m_axis_tdata_o[15:0] == 16'd0) && !m_axis_tdata_o[42])
    else $error("idle result carries a process");

  a_admit_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == ST_READY || m_axis_tuser_o == ST_WAITING ||
      m_axis_tuser_o == ST_TOO_MANY || m_axis_tuser_o == ST_FULL) |->
      (m_axis_tdata_o[25:18] == 8'd0) && (m_axis_tdata_o[87:83] == 5'd0))
    else $error("admit result shows a slice or promotions");

endmodule

bind mlfq_scheduler_thread_admission_top mlfq_checker u_mlfq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
